// ===== rtl/core/dpti_pkg.sv =====
package dpti_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int POW_W     = SQ_W + 1;
    localparam int NUM_CH_W  = 13;
    localparam int CHAN_W    = 12;
    localparam int ICNT_W    = 16;
    localparam int FRAME_W   = 29;
    localparam int INTEG_W   = 44;
    localparam int TS_W      = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DAT_W  = 4 * SAMPLE_W;
    localparam int OUT_DAT_W = 128;

    localparam logic [NUM_CH_W-1:0] MAX_CHANNELS = NUM_CH_W'(4096);
    localparam logic [FRAME_W-1:0]  FRAME_MAX    = '1;
    localparam logic [INTEG_W-1:0]  INTEG_MAX    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CHANNELS    = 1'b0,
        CFG_INTEGRATE_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] y_imag;
        logic signed [SAMPLE_W-1:0] y_real;
        logic signed [SAMPLE_W-1:0] x_imag;
        logic signed [SAMPLE_W-1:0] x_real;
    } t_sample;

endpackage

// ===== rtl/core/dpti_power.sv =====
module dpti_power (
    input  dpti_pkg::t_sample                 i_sample,
    output logic [dpti_pkg::POW_W-1:0]        o_power
);

    logic [dpti_pkg::SAMPLE_W-1:0] w_mag [4];
    logic [dpti_pkg::SQ_W-1:0]     w_sq  [4];
    logic [dpti_pkg::SAMPLE_W-1:0] w_raw [4];

    assign w_raw[0] = i_sample.x_real;
    assign w_raw[1] = i_sample.x_imag;
    assign w_raw[2] = i_sample.y_real;
    assign w_raw[3] = i_sample.y_imag;

    // The magnitude of the most negative value still fits as unsigned.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mag[k] = w_raw[k][dpti_pkg::SAMPLE_W-1] ? (~w_raw[k] + 1'b1) : w_raw[k];
            w_sq[k]  = dpti_pkg::SQ_W'(w_mag[k]) * dpti_pkg::SQ_W'(w_mag[k]);
        end
        o_power = dpti_pkg::POW_W'(w_sq[0]) + dpti_pkg::POW_W'(w_sq[1])
                + dpti_pkg::POW_W'(w_sq[2]) + dpti_pkg::POW_W'(w_sq[3]);
    end

endmodule

// ===== rtl/core/dual_pol_total_power_integrator.sv =====
// Channel     Direction  Fields (lowest bit first)
// s_axis      in         tdata: x_real, x_imag, y_real, y_imag
// m_axis      out        tdata: timestep, frame_power, integrated_power; tuser: integrated_valid
// i_cfg       in         index 0 num_channels, index 1 integrate_count
//
// One sample per clock is sustained while no frame-ending sample waits; a result is
// presented once the last sample of its frame passes the power and output registers.
// The first stage registers the power, the second updates the frame and integration
// sums and loads the output register. Only a frame-ending sample waits when the
// output register is full. Reset is synchronous and clears all counters and sums.
module dual_pol_total_power_integrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_real, x_imag, y_real, y_imag
    input  logic [dpti_pkg::IN_DAT_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // timestep, frame_power, integrated_power, zero fill
    output logic [dpti_pkg::OUT_DAT_W-1:0]      m_axis_tdata,
    // integrated_valid
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [dpti_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dpti_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    logic [dpti_pkg::NUM_CH_W-1:0] r_num_ch;
    logic [dpti_pkg::ICNT_W-1:0]   r_icnt;

    logic                          r_pvalid;
    logic [dpti_pkg::POW_W-1:0]    r_pow;
    logic [dpti_pkg::POW_W-1:0]    w_pow;

    logic [dpti_pkg::CHAN_W-1:0]   r_chan;
    logic [dpti_pkg::FRAME_W-1:0]  r_facc;
    logic [dpti_pkg::ICNT_W-1:0]   r_fcnt;
    logic [dpti_pkg::INTEG_W-1:0]  r_iacc;
    logic [dpti_pkg::TS_W-1:0]     r_ts;

    logic                          r_ovalid;
    logic [dpti_pkg::TS_W-1:0]     r_o_ts;
    logic [dpti_pkg::FRAME_W-1:0]  r_o_fp;
    logic                          r_o_iv;
    logic [dpti_pkg::INTEG_W-1:0]  r_o_ip;

    logic [dpti_pkg::NUM_CH_W-1:0] w_eff;
    logic                          w_last;
    logic [dpti_pkg::FRAME_W:0]    w_fsum;
    logic [dpti_pkg::FRAME_W-1:0]  n_facc;
    logic [dpti_pkg::INTEG_W:0]    w_isum;
    logic [dpti_pkg::INTEG_W-1:0]  n_iacc;
    logic [dpti_pkg::ICNT_W-1:0]   n_fcnt;
    logic                          w_hit;
    logic                          w_out_free;
    logic                          w_adv;

    dpti_power u_power (
        .i_sample (dpti_pkg::t_sample'(s_axis_tdata)),
        .o_power  (w_pow)
    );

    always_comb begin
        if (r_num_ch == '0) begin
            w_eff = dpti_pkg::NUM_CH_W'(1);
        end else if (r_num_ch > dpti_pkg::MAX_CHANNELS) begin
            w_eff = dpti_pkg::MAX_CHANNELS;
        end else begin
            w_eff = r_num_ch;
        end
        w_last = (dpti_pkg::NUM_CH_W'(r_chan) + 1'b1) >= w_eff;

        w_fsum = {1'b0, r_facc} + (dpti_pkg::FRAME_W + 1)'(r_pow);
        n_facc = (w_fsum > {1'b0, dpti_pkg::FRAME_MAX}) ? dpti_pkg::FRAME_MAX
                                                         : w_fsum[dpti_pkg::FRAME_W-1:0];
        w_isum = {1'b0, r_iacc} + (dpti_pkg::INTEG_W + 1)'(n_facc);
        n_iacc = (w_isum > {1'b0, dpti_pkg::INTEG_MAX}) ? dpti_pkg::INTEG_MAX
                                                         : w_isum[dpti_pkg::INTEG_W-1:0];
        n_fcnt = r_fcnt + 1'b1;
        w_hit  = (r_icnt != '0) && (n_fcnt == r_icnt);

        w_out_free    = !r_ovalid || m_axis_tready;
        w_adv         = r_pvalid && (!w_last || w_out_free);
        s_axis_tready = !r_pvalid || w_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch <= dpti_pkg::NUM_CH_W'(1);
            r_icnt   <= '0;
        end else if (i_cfg_we) begin
            case (dpti_pkg::t_cfg_idx'(i_cfg_idx))
                dpti_pkg::CFG_NUM_CHANNELS: begin
                    r_num_ch <= i_cfg_data[dpti_pkg::NUM_CH_W-1:0];
                end
                dpti_pkg::CFG_INTEGRATE_COUNT: begin
                    r_icnt <= i_cfg_data[dpti_pkg::ICNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else if (s_axis_tready) begin
            r_pvalid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_pow <= w_pow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_facc <= '0;
            r_fcnt <= '0;
            r_iacc <= '0;
            r_ts   <= '0;
        end else if (w_adv) begin
            if (!w_last) begin
                r_chan <= r_chan + 1'b1;
                r_facc <= n_facc;
            end else begin
                r_chan <= '0;
                r_facc <= '0;
                r_iacc <= w_hit ? '0 : n_iacc;
                r_fcnt <= w_hit ? '0 : n_fcnt;
                r_ts   <= r_ts + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_adv && w_last) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last) begin
            r_o_ts <= r_ts;
            r_o_fp <= n_facc;
            r_o_iv <= w_hit;
            r_o_ip <= w_hit ? n_iacc : '0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_iv;
    assign m_axis_tdata  = {7'd0, r_o_ip, r_o_fp, r_o_ts};

    a_no_ip_without_iv : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_o_iv) |-> (r_o_ip == '0))
        else $error("integrated power set without its flag");

    a_ip_covers_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_iv) |-> (r_o_ip >= dpti_pkg::INTEG_W'(r_o_fp)))
        else $error("integrated power below its last frame power");

    a_hit_clears_fcnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last && w_hit) |=> (r_fcnt == '0 && r_iacc == '0 && r_o_iv))
        else $error("integration not cleared after a completed sum");

endmodule
